### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the scheduler modules. They expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define TLFRR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tlfrr: assertion failed");
// Checked on every rising clock edge, reset included.
`define TLFRR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tlfrr: assertion failed");
`else
`define TLFRR_ASSERT(label, clk, rst_n, prop)
`define TLFRR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### sv/tlfrr_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Field widths, codes and the structures passed between the controller and
// the datapath.
// ----------------------------------------------------------------------------
package tlfrr_pkg;

    localparam int ID_W     = 3;
    localparam int TIME_W   = 16;
    localparam int Q_W      = 8;
    localparam int DONE_W   = 4;
    localparam int EV_W     = 2;
    localparam int NUM_IDS  = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [DONE_W-1:0] DONE_MAX    = 4'd15;
    localparam logic [Q_W-1:0]    QUANTUM_RST = 8'd2;

    // Item kinds.
    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_QUANTUM = 1'b0;

    typedef enum logic [EV_W-1:0] {
        EV_IDLE    = 2'd0,
        EV_CONT    = 2'd1,
        EV_PREEMPT = 2'd2,
        EV_DONE    = 2'd3
    } t_event;

    typedef struct packed {
        logic              ran_valid;
        logic [ID_W-1:0]   ran_id;
        logic              from_low;
        logic [TIME_W-1:0] time_left;
        logic [EV_W-1:0]   event_res;
        logic [DONE_W-1:0] completed_total;
    } t_result;

    typedef struct packed {
        logic arrive_wr;  // arrive item accepted this cycle
        logic fetch;      // read both queue heads
        logic latch_run;  // pick the runner and read its remaining time
        logic exec_go;    // commit the tick and load the result register
    } t_cmd;

    typedef struct packed {
        logic out_free;   // result register can take a new item
    } t_sts;

endpackage

### sv/tlfrr_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one arrive or tick item.
// ----------------------------------------------------------------------------
interface tlfrr_in_if import tlfrr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              kind;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] service_time;

    modport source (output valid, output kind, output proc_id, output service_time,
                    input ready);
    modport sink   (input valid, input kind, input proc_id, input service_time,
                    output ready);

endinterface

### sv/tlfrr_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one tick result item.
// ----------------------------------------------------------------------------
interface tlfrr_out_if import tlfrr_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              ran_valid;
    logic [ID_W-1:0]   ran_id;
    logic              from_low;
    logic [TIME_W-1:0] time_left;
    logic [EV_W-1:0]   event_res;
    logic [DONE_W-1:0] completed_total;

    modport source (output valid, output ran_valid, output ran_id, output from_low,
                    output time_left, output event_res, output completed_total,
                    input ready);
    modport sink   (input valid, input ran_valid, input ran_id, input from_low,
                    input time_left, input event_res, input completed_total,
                    output ready);

endinterface

### sv/tlfrr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlfrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tlfrr_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one item at a time: arrive items finish at acceptance, tick
// items walk through the queue-head read, the time read and the commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlfrr_ctrl import tlfrr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_vld,
    input  logic i_in_kind,
    output logic o_in_rdy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_TIME  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_fire;

    assign o_in_rdy = (r_state == S_IDLE);
    assign w_fire   = i_in_vld && o_in_rdy;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.arrive_wr = w_fire && (i_in_kind == KIND_ARRIVE);
        case (r_state)
            S_IDLE: begin
                if (w_fire && (i_in_kind == KIND_TICK)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_TIME;
            end
            S_TIME: begin
                o_cmd.latch_run = 1'b1;
                n_state         = S_EXEC;
            end
            S_EXEC: begin
                // Hold here until the result register has room.
                o_cmd.exec_go = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `TLFRR_ASSERT(a_exec_stall, i_clk, i_rst_n, (r_state == S_EXEC) && !i_sts.out_free |=> (r_state == S_EXEC))
    `TLFRR_ASSERT(a_arrive_single, i_clk, i_rst_n, o_cmd.arrive_wr |=> (r_state == S_IDLE))

endmodule

### sv/tlfrr_dp.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Both id queues, the remaining-time store, the slice and completion
// counters and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlfrr_dp import tlfrr_pkg::*; #(
    parameter int NUM_PROCS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [ID_W-1:0]   i_proc_id,
    input  logic [TIME_W-1:0] i_service_time,
    input  logic [Q_W-1:0]    i_quantum,
    input  logic              i_out_rdy,
    output logic              o_out_vld,
    output t_result           o_out
);

    localparam int PTR_W = $clog2(NUM_PROCS);
    localparam int CNT_W = $clog2(NUM_PROCS + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int TA_W  = $clog2(NUM_IDS);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_PROCS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_PROCS - 1);
    localparam logic [SUM_W-1:0] SUM_N    = SUM_W'(NUM_PROCS);

    // Queue pointers and counts.
    logic [PTR_W-1:0] r_hi_head, n_hi_head, r_lo_head, n_lo_head;
    logic [CNT_W-1:0] r_hi_cnt,  n_hi_cnt,  r_lo_cnt,  n_lo_cnt;

    // Scheduling state.
    logic [Q_W-1:0]    r_slice, n_slice;
    logic              r_last_vld, n_last_vld;
    logic [ID_W-1:0]   r_last_id, n_last_id;
    logic [DONE_W-1:0] r_done, n_done;

    // The tick in flight.
    logic            r_run_vld;
    logic            r_run_low;
    logic [ID_W-1:0] r_run_id;

    // Result register.
    logic    r_out_vld, n_out_vld;
    t_result r_out;

    logic [ID_W-1:0]   w_hi_rdata, w_lo_rdata;
    logic [TIME_W-1:0] w_time_rdata;
    logic [SUM_W-1:0]  w_hi_sum, w_lo_sum, w_queued;
    logic [PTR_W-1:0]  w_hi_tail, w_lo_tail, w_hi_inc, w_lo_inc;
    logic              w_arrive_ok;
    logic              w_sel_low, w_sel_vld;
    logic [ID_W-1:0]   w_sel_id;
    logic [TIME_W-1:0] w_t_new;
    logic [Q_W-1:0]    w_slice_inc;
    logic              w_complete, w_preempt, w_commit;
    logic              w_lo_push;
    t_event            w_event;
    logic              w_time_we;
    logic [TA_W-1:0]   w_time_waddr;
    logic [TIME_W-1:0] w_time_wdata;

    // Tail = head + count, wrapped once at the queue depth.
    assign w_hi_sum  = SUM_W'(r_hi_head) + SUM_W'(r_hi_cnt);
    assign w_lo_sum  = SUM_W'(r_lo_head) + SUM_W'(r_lo_cnt);
    assign w_hi_tail = (w_hi_sum >= SUM_N) ? PTR_W'(w_hi_sum - SUM_N) : PTR_W'(w_hi_sum);
    assign w_lo_tail = (w_lo_sum >= SUM_N) ? PTR_W'(w_lo_sum - SUM_N) : PTR_W'(w_lo_sum);
    assign w_hi_inc  = (r_hi_head == PTR_LAST) ? '0 : r_hi_head + PTR_W'(1);
    assign w_lo_inc  = (r_lo_head == PTR_LAST) ? '0 : r_lo_head + PTR_W'(1);
    assign w_queued  = SUM_W'(r_hi_cnt) + SUM_W'(r_lo_cnt);

    // Arrivals with an out-of-range id or a full high queue are dropped.
    assign w_arrive_ok = i_cmd.arrive_wr && (32'(i_proc_id) < NUM_PROCS)
                         && (r_hi_cnt != CNT_FULL);

    // Runner selection: high queue first.
    assign w_sel_low = (r_hi_cnt == '0);
    assign w_sel_vld = (r_hi_cnt != '0) || (r_lo_cnt != '0);
    assign w_sel_id  = w_sel_low ? w_lo_rdata : w_hi_rdata;

    // Tick evaluation; a stored time of zero still completes.
    assign w_t_new     = (w_time_rdata == '0) ? '0 : w_time_rdata - TIME_W'(1);
    assign w_slice_inc = ((r_last_vld && (r_last_id == r_run_id)) ? r_slice : '0)
                         + Q_W'(1);
    assign w_complete  = (w_t_new == '0);
    assign w_preempt   = !w_complete && (w_slice_inc >= i_quantum);
    assign w_commit    = i_cmd.exec_go && r_run_vld;
    // A preempted low runner frees its own slot, so its push always fits.
    assign w_lo_push   = w_commit && w_preempt && (r_run_low || (r_lo_cnt != CNT_FULL));

    always_comb begin
        if (!r_run_vld) begin
            w_event = EV_IDLE;
        end else if (w_complete) begin
            w_event = EV_DONE;
        end else if (w_preempt) begin
            w_event = EV_PREEMPT;
        end else begin
            w_event = EV_CONT;
        end
    end

    assign w_time_we    = w_arrive_ok || w_commit;
    assign w_time_waddr = w_arrive_ok ? TA_W'(i_proc_id) : TA_W'(r_run_id);
    assign w_time_wdata = w_arrive_ok ? i_service_time : w_t_new;

    tlfrr_ram #(.WIDTH(ID_W), .DEPTH(NUM_PROCS)) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (w_arrive_ok),
        .i_waddr (w_hi_tail),
        .i_wdata (i_proc_id),
        .i_re    (i_cmd.fetch),
        .i_raddr (r_hi_head),
        .o_rdata (w_hi_rdata)
    );

    tlfrr_ram #(.WIDTH(ID_W), .DEPTH(NUM_PROCS)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (w_lo_push),
        .i_waddr (w_lo_tail),
        .i_wdata (r_run_id),
        .i_re    (i_cmd.fetch),
        .i_raddr (r_lo_head),
        .o_rdata (w_lo_rdata)
    );

    tlfrr_ram #(.WIDTH(TIME_W), .DEPTH(NUM_IDS)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_time_we),
        .i_waddr (w_time_waddr),
        .i_wdata (w_time_wdata),
        .i_re    (i_cmd.latch_run),
        .i_raddr (TA_W'(w_sel_id)),
        .o_rdata (w_time_rdata)
    );

    always_comb begin
        n_hi_head  = r_hi_head;
        n_hi_cnt   = r_hi_cnt;
        n_lo_head  = r_lo_head;
        n_lo_cnt   = r_lo_cnt;
        n_slice    = r_slice;
        n_last_vld = r_last_vld;
        n_last_id  = r_last_id;
        n_done     = r_done;

        if (w_arrive_ok) begin
            n_hi_cnt = r_hi_cnt + CNT_W'(1);
        end

        if (w_commit) begin
            n_last_vld = 1'b1;
            n_last_id  = r_run_id;
            n_slice    = (w_complete || w_preempt) ? '0 : w_slice_inc;
            if (w_complete && (r_done != DONE_MAX)) begin
                n_done = r_done + DONE_W'(1);
            end
            if (w_complete || w_preempt) begin
                if (r_run_low) begin
                    n_lo_head = w_lo_inc;
                    // Pop and re-push on preemption leave the count unchanged.
                    n_lo_cnt  = w_preempt ? r_lo_cnt : r_lo_cnt - CNT_W'(1);
                end else begin
                    n_hi_head = w_hi_inc;
                    n_hi_cnt  = r_hi_cnt - CNT_W'(1);
                    if (w_lo_push) begin
                        n_lo_cnt = r_lo_cnt + CNT_W'(1);
                    end
                end
            end
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_rdy;

    always_comb begin
        n_out_vld = r_out_vld;
        if (i_cmd.exec_go) begin
            n_out_vld = 1'b1;
        end else if (i_out_rdy) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_head  <= '0;
            r_hi_cnt   <= '0;
            r_lo_head  <= '0;
            r_lo_cnt   <= '0;
            r_slice    <= '0;
            r_last_vld <= 1'b0;
            r_last_id  <= '0;
            r_done     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_hi_head  <= n_hi_head;
            r_hi_cnt   <= n_hi_cnt;
            r_lo_head  <= n_lo_head;
            r_lo_cnt   <= n_lo_cnt;
            r_slice    <= n_slice;
            r_last_vld <= n_last_vld;
            r_last_id  <= n_last_id;
            r_done     <= n_done;
            r_out_vld  <= n_out_vld;
        end
    end

    // Runner capture and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_run) begin
            r_run_vld <= w_sel_vld;
            r_run_low <= w_sel_low;
            r_run_id  <= w_sel_id;
        end
        if (i_cmd.exec_go) begin
            r_out.ran_valid       <= r_run_vld;
            r_out.ran_id          <= r_run_vld ? r_run_id : '0;
            r_out.from_low        <= r_run_vld && r_run_low;
            r_out.time_left       <= r_run_vld ? w_t_new : '0;
            r_out.event_res       <= w_event;
            r_out.completed_total <= n_done;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_out     = r_out;

    `TLFRR_ASSERT(a_cnt_bound, i_clk, i_rst_n, (r_hi_cnt <= CNT_FULL) && (r_lo_cnt <= CNT_FULL))
    `TLFRR_ASSERT(a_done_on_commit, i_clk, i_rst_n, (r_done != $past(r_done)) |-> $past(i_cmd.exec_go))
    `TLFRR_ASSERT(a_tick_no_growth, i_clk, i_rst_n, $past(i_cmd.exec_go) |-> (w_queued <= $past(w_queued)))

endmodule

### sv/two_level_feedback_round_robin.sv
// Latency: an arrive item completes at the edge that accepts it; the input is ready again
// in the next cycle. A tick item blocks the input through S_FETCH and S_TIME, two registered
// memory reads in series (queue head, then that id's remaining time), and S_EXEC, which
// loads the result register once it has room. Throughput: one arrive item per cycle while
// idle. Reset: synchronous, active low. Both queues empty, counters zero, quantum 2. No
// clearing pass; queue slots and remaining times are only read after they have been written.
// ----------------------------------------------------------------------------
// Two-level feedback round-robin scheduler
// Holds process ids in a high-priority and a low-priority queue and runs one
// time unit per tick item, demoting a process after a quantum of ticks.
// ----------------------------------------------------------------------------
module two_level_feedback_round_robin import tlfrr_pkg::*; #(
    parameter int NUM_PROCS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlfrr_in_if.sink          i_in,
    tlfrr_out_if.source       o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Configuration register. The quantum sits at byte address 0; the
    // register index is taken from paddr[2] and a write to any other index
    // is ignored.
    logic [Q_W-1:0] r_quantum;
    logic [Q_W-1:0] n_quantum;
    logic           w_cfg_wr;

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_res;
    logic    w_out_vld;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_quantum = r_quantum;
        if (w_cfg_wr && (paddr[2] == REG_QUANTUM)) begin
            n_quantum = pwdata[Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RST;
        end else begin
            r_quantum <= n_quantum;
        end
    end

    assign prdata = (paddr[2] == REG_QUANTUM) ? APB_DW'(r_quantum) : '0;

    // The controller only sees the handshake and the item kind; every
    // payload bit goes straight into the datapath.
    tlfrr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (i_in.valid),
        .i_in_kind (i_in.kind),
        .o_in_rdy  (i_in.ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // The datapath owns the queues, the remaining-time store and the result
    // register, so a finished result can wait on the output while the next
    // arrive items are taken.
    tlfrr_dp #(.NUM_PROCS(NUM_PROCS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_proc_id      (i_in.proc_id),
        .i_service_time (i_in.service_time),
        .i_quantum      (r_quantum),
        .i_out_rdy      (o_out.ready),
        .o_out_vld      (w_out_vld),
        .o_out          (w_res)
    );

    assign o_out.valid           = w_out_vld;
    assign o_out.ran_valid       = w_res.ran_valid;
    assign o_out.ran_id          = w_res.ran_id;
    assign o_out.from_low        = w_res.from_low;
    assign o_out.time_left       = w_res.time_left;
    assign o_out.event_res       = w_res.event_res;
    assign o_out.completed_total = w_res.completed_total;

endmodule

### dv/two_level_feedback_round_robin_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level feedback round-robin scheduler testbench
// A scripted opening sequence covers idle ticks, completion, zero and
// maximum service times, preemption, re-arrival of a queued id and a full
// high queue. Random arrive and tick bursts follow under several quantum
// settings, with random source gaps and sink stalls. Every tick result is
// checked against a typed row result or a cycle-free model kept in this bench.
// ----------------------------------------------------------------------------
module two_level_feedback_round_robin_tb import tlfrr_pkg::*; ();

    localparam int HIQ = 0;
    localparam int LOQ = 1;
    localparam logic [APB_AW-1:0] QUANTUM_ADDR = {REG_QUANTUM, 2'b00};
    localparam int N_PHASES   = 5;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_CYCLES = 300;
    localparam t_result NO_RES = '0;

    // One row of the scripted opening sequence. When has_exp is set, the
    // result typed into the row is the expectation for that tick.
    typedef struct {
        logic              kind;
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] svc;
        bit                has_exp;
        t_result           res;
    } t_sched_row;

    logic i_clk;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    tlfrr_in_if  in_if ();
    tlfrr_out_if out_if ();

    two_level_feedback_round_robin dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Scheduler model state. It mirrors the block after reset: both queues
    // empty, counters zero, quantum at its reset value. Queue slots and the
    // time table are only read after they have been written.
    // ------------------------------------------------------------------------
    logic [ID_W-1:0]   q_slot [2][NUM_IDS];
    int                q_head [2] = '{0, 0};
    int                q_cnt  [2] = '{0, 0};
    logic [TIME_W-1:0] time_tab [NUM_IDS];
    logic [Q_W-1:0]    slice_cnt   = '0;
    bit                last_ok     = 1'b0;
    logic [ID_W-1:0]   last_id     = '0;
    logic [DONE_W-1:0] done_cnt    = '0;
    logic [Q_W-1:0]    quantum_reg = QUANTUM_RST;

    // Results still owed by the block, oldest first.
    t_result pending_runs [$];

    // Bookkeeping for the summary and the verdict.
    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int n_idle       = 0;
    int n_done       = 0;
    int n_preempt    = 0;
    int n_dropped    = 0;
    int n_ignored    = 0;

    // Traffic shaping shared between the source, the sink and the sequencer.
    int gap_pct  = 0;
    bit stall_on = 1'b0;
    bit hold_req = 1'b0;

    t_sched_row dir_rows [24];

    // ------------------------------------------------------------------------
    // Clock and the single reset at the start of the run.
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // The whole run is bounded here; a hang in any handshake lands on this.
    initial begin
        #2000000;
        $display("[two_level_feedback_round_robin] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model helpers. The queues are plain circular buffers of NUM_IDS slots.
    // ------------------------------------------------------------------------
    function automatic bit q_push(int q, logic [ID_W-1:0] id);
        if (q_cnt[q] >= NUM_IDS) begin
            return 1'b0;
        end
        q_slot[q][(q_head[q] + q_cnt[q]) % NUM_IDS] = id;
        q_cnt[q]++;
        return 1'b1;
    endfunction

    function automatic void q_pop(int q);
        if (q_cnt[q] != 0) begin
            q_head[q] = (q_head[q] + 1) % NUM_IDS;
            q_cnt[q]--;
        end
    endfunction

    // An arrival overwrites the id's remaining time and queues it high,
    // unless the high queue is already full, in which case nothing happens.
    function automatic void sched_arrive(logic [ID_W-1:0] id, logic [TIME_W-1:0] svc);
        if (q_cnt[HIQ] < NUM_IDS) begin
            time_tab[id] = svc;
            void'(q_push(HIQ, id));
        end else begin
            n_ignored++;
        end
    endfunction

    // One time unit of scheduling: the high head wins over the low head.
    // The consecutive-tick count restarts whenever a different id runs and
    // after every completion or preemption. A zero time completes at once.
    function automatic t_result sched_tick();
        t_result           r;
        int                q;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] t;
        t_event            ev;
        r = '0;
        if (q_cnt[HIQ] != 0) begin
            q = HIQ;
        end else if (q_cnt[LOQ] != 0) begin
            q = LOQ;
        end else begin
            n_idle++;
            r.completed_total = done_cnt;
            return r;
        end
        id = q_slot[q][q_head[q]];
        if (!last_ok || last_id != id) begin
            slice_cnt = '0;
        end
        last_ok = 1'b1;
        last_id = id;
        t = time_tab[id];
        if (t != 0) begin
            t--;
        end
        time_tab[id] = t;
        slice_cnt++;
        if (t == 0) begin
            q_pop(q);
            if (done_cnt != DONE_MAX) begin
                done_cnt++;
            end
            slice_cnt = '0;
            ev = EV_DONE;
            n_done++;
        end else if (slice_cnt >= quantum_reg) begin
            // A quantum of zero preempts after every tick, like a quantum of one.
            q_pop(q);
            if (!q_push(LOQ, id)) begin
                n_dropped++;
            end
            slice_cnt = '0;
            ev = EV_PREEMPT;
            n_preempt++;
        end else begin
            ev = EV_CONT;
        end
        r.ran_valid       = 1'b1;
        r.ran_id          = id;
        r.from_low        = (q == LOQ);
        r.time_left       = t;
        r.event_res       = ev;
        r.completed_total = done_cnt;
        return r;
    endfunction

    function automatic t_result mk_res(logic rv, logic [ID_W-1:0] id, logic lo,
                                       logic [TIME_W-1:0] t, t_event ev,
                                       logic [DONE_W-1:0] total);
        t_result r;
        r.ran_valid       = rv;
        r.ran_id          = id;
        r.from_low        = lo;
        r.time_left       = t;
        r.event_res       = ev;
        r.completed_total = total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Source side. Fields change on the falling edge; the item is taken at
    // the first rising edge with ready high, and the model advances right
    // there so that its order is the acceptance order.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_sched_row row);
        int      gap;
        t_result pred;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 15);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.kind         <= row.kind;
        in_if.proc_id      <= row.pid;
        in_if.service_time <= row.svc;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        if (row.kind == KIND_ARRIVE) begin
            sched_arrive(row.pid, row.svc);
        end else begin
            pred = sched_tick();
            pending_runs.push_back(row.has_exp ? row.res : pred);
        end
        @(negedge i_clk);
    endtask

    // Register writes go out only while the block is quiet, once every owed
    // result has arrived.
    task automatic settle();
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Setup cycle, then the access cycle; pready is always high, so the
    // register takes the value at the rising edge inside the access cycle.
    task automatic write_quantum(input logic [Q_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= QUANTUM_ADDR;
        pwdata  <= APB_DW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        quantum_reg = val;
        @(negedge i_clk);
    endtask

    // Service times lean small so that completions are frequent, with the
    // zero and all-ones extremes and the full range mixed in.
    function automatic logic [TIME_W-1:0] pick_svc();
        int sel;
        sel = $urandom_range(0, 31);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return '1;
        end else if (sel < 6) begin
            return TIME_W'($urandom_range(0, 65535));
        end
        return TIME_W'($urandom_range(1, 12));
    endfunction

    // ------------------------------------------------------------------------
    // Sink side: random stall bursts, one long hold-off on request, and
    // ready held high whenever stalls are switched off.
    // ------------------------------------------------------------------------
    initial begin
        int n;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // The block's single result slot fills, then ticks back up
                // into the source while this counts down.
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                out_if.ready <= 1'b1;
            end else if (stall_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 15);
                out_if.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Every accepted result is matched field by field with
    // the oldest owed result; a result with nothing owed is also a failure.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        bit      bad;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            got = mk_res(out_if.ran_valid, out_if.ran_id, out_if.from_low,
                         out_if.time_left, t_event'(out_if.event_res),
                         out_if.completed_total);
            if (pending_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: ran=%0d id=%0d low=%0d left=%0d ev=%0d done=%0d",
                             got.ran_valid, got.ran_id, got.from_low, got.time_left,
                             got.event_res, got.completed_total);
                end
            end else begin
                exp_r = pending_runs.pop_front();
                bad = (got.ran_valid != exp_r.ran_valid) || (got.ran_id != exp_r.ran_id)
                   || (got.from_low != exp_r.from_low) || (got.time_left != exp_r.time_left)
                   || (got.event_res != exp_r.event_res)
                   || (got.completed_total != exp_r.completed_total);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d mismatch at %0t", results_seen, $realtime);
                        $display("  expected ran=%0d id=%0d low=%0d left=%0d ev=%0d done=%0d",
                                 exp_r.ran_valid, exp_r.ran_id, exp_r.from_low,
                                 exp_r.time_left, exp_r.event_res, exp_r.completed_total);
                        $display("  actual   ran=%0d id=%0d low=%0d left=%0d ev=%0d done=%0d",
                                 got.ran_valid, got.ran_id, got.from_low, got.time_left,
                                 got.event_res, got.completed_total);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: scripted opening, then one random phase per quantum setting.
    // ------------------------------------------------------------------------
    initial begin
        logic [Q_W-1:0] q_list [N_PHASES];
        t_sched_row     row;
        int             sent;
        int             burst;
        bit             do_arrive;

        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.kind         = KIND_ARRIVE;
        in_if.proc_id      = '0;
        in_if.service_time = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;

        // Quantum of one, the maximum, zero (treated as one, and lowered
        // from the maximum while a process may be mid-slice), a small
        // value, and a random one for the final phase without idling.
        q_list = '{8'd1, 8'd255, 8'd0, 8'd3, Q_W'($urandom_range(1, 255))};

        // Opening script, quantum at its reset value of two. The rows walk
        // through an idle tick, one-tick and zero-time completions, the
        // largest service time running until preemption, a second process
        // that is demoted too, the low queue taking over, a queued id that
        // arrives again, and a ninth arrival that finds the high queue full.
        dir_rows = '{
            '{KIND_TICK,   3'd0, 16'd0,     1'b1, mk_res(1'b0, 3'd0, 1'b0, 16'd0, EV_IDLE, 4'd0)},
            '{KIND_ARRIVE, 3'd0, 16'd1,     1'b0, NO_RES},
            '{KIND_TICK,   3'd0, 16'd0,     1'b1, mk_res(1'b1, 3'd0, 1'b0, 16'd0, EV_DONE, 4'd1)},
            '{KIND_ARRIVE, 3'd7, 16'd0,     1'b0, NO_RES},
            '{KIND_TICK,   3'd0, 16'd0,     1'b1, mk_res(1'b1, 3'd7, 1'b0, 16'd0, EV_DONE, 4'd2)},
            '{KIND_ARRIVE, 3'd3, 16'hFFFF,  1'b0, NO_RES},
            '{KIND_TICK,   3'd0, 16'd0,     1'b1,
              mk_res(1'b1, 3'd3, 1'b0, 16'd65534, EV_CONT, 4'd2)},
            '{KIND_TICK,   3'd0, 16'd0,     1'b1,
              mk_res(1'b1, 3'd3, 1'b0, 16'd65533, EV_PREEMPT, 4'd2)},
            '{KIND_ARRIVE, 3'd5, 16'd3,     1'b0, NO_RES},
            '{KIND_TICK,   3'd0, 16'd0,     1'b0, NO_RES},
            '{KIND_TICK,   3'd0, 16'd0,     1'b0, NO_RES},
            '{KIND_TICK,   3'd0, 16'd0,     1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd3, 16'd2,     1'b0, NO_RES},
            '{KIND_TICK,   3'd0, 16'd0,     1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd0, 16'hAAAA,  1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd1, 16'h5555,  1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd2, 16'd2,     1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd3, 16'hFFFF,  1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd4, 16'h0010,  1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd5, 16'h8000,  1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd6, 16'd4,     1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd7, 16'h7FFF,  1'b0, NO_RES},
            '{KIND_ARRIVE, 3'd6, 16'h1234,  1'b0, NO_RES},
            '{KIND_TICK,   3'd0, 16'd0,     1'b0, NO_RES}
        };

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct  = 15;
        stall_on = 1'b1;
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i]);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
            settle();
            write_quantum(q_list[p]);

            // The final phase runs with no source gaps and no sink stalls.
            stall_on = (p != N_PHASES - 1);
            // The long sink hold-off comes once, in the quantum-one phase,
            // where the sequencer keeps offering ticks into it.
            if (p == 0) begin
                hold_req = 1'b1;
            end

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // Each burst is either all arrivals or all ticks, and some
                // bursts run without source gaps. Long arrival bursts fill
                // the high queue; long tick runs under a small quantum fill
                // the low queue until a preempted process is dropped.
                gap_pct = (stall_on && $urandom_range(0, 3) != 0) ? 20 : 0;
                do_arrive = ($urandom_range(0, 2) == 0);
                if (do_arrive) begin
                    burst = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12)
                                                        : $urandom_range(1, 4);
                end else begin
                    burst = $urandom_range(1, 16);
                end
                repeat (burst) begin
                    row.kind    = do_arrive ? KIND_ARRIVE : KIND_TICK;
                    row.pid     = ID_W'($urandom_range(0, NUM_IDS - 1));
                    row.svc     = pick_svc();
                    row.has_exp = 1'b0;
                    row.res     = NO_RES;
                    send_item(row);
                    sent++;
                end
            end
        end

        in_if.valid <= 1'b0;
        settle();
        repeat (16) @(posedge i_clk);

        $display("covered %0d items, %0d results: %0d idle, %0d completed, %0d preempted",
                 items_sent, results_seen, n_idle, n_done, n_preempt);
        $display("high-queue-full arrivals %0d, low-queue-full drops %0d, quantum settings %0d",
                 n_ignored, n_dropped, N_PHASES + 1);
        if (mismatches == 0 && pending_runs.size() == 0) begin
            $display("[two_level_feedback_round_robin] OK");
        end else begin
            $display("[two_level_feedback_round_robin] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/tlfrr_pkg.sv
sv/tlfrr_in_if.sv
sv/tlfrr_out_if.sv
sv/tlfrr_ram.sv
sv/tlfrr_ctrl.sv
sv/tlfrr_dp.sv
sv/two_level_feedback_round_robin.sv
dv/two_level_feedback_round_robin_tb.sv
